// ===== rtl/nts_pkg.sv =====
// Shared types and constants for the n-gram table fragment search block.
// No dependencies; every other file imports it.
package nts_pkg;

  // Channel field widths
  localparam int OPCODE_W = 1;
  localparam int NGRAM_W  = 24;
  localparam int FRAG_W   = 24;
  localparam int FLEN_W   = 2;
  localparam int OFF_W    = 14;
  localparam int STATUS_W = 2;

  // Bytes held in one stored word; higher bytes of a wider n-gram read as zero
  localparam int STORED_BYTES = 3;
  // Position of a match inside one n-gram (n-grams are at most 8 bytes)
  localparam int POS_W = 3;

  // Parameter defaults
  localparam int NGRAM_BYTES_DEF   = 3;
  localparam int TABLE_ENTRIES_DEF = 4096;

  localparam logic [OPCODE_W-1:0] OP_LOAD   = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_SEARCH = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic             hit;
    logic [POS_W-1:0] pos;
  } match_res_t;

endpackage

// ===== rtl/nts_if.sv =====
// Valid/ready channel interfaces for the search block's item and result streams.
// Depends on nts_pkg for field widths.
interface nts_in_if
  import nts_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [NGRAM_W-1:0]  entry_bytes;
  logic [FRAG_W-1:0]   fragment_bytes;
  logic [FLEN_W-1:0]   fragment_len;
  logic [OFF_W-1:0]    start_offset;

  modport source (output valid, opcode, entry_bytes, fragment_bytes, fragment_len,
                  start_offset, input ready);
  modport sink   (input valid, opcode, entry_bytes, fragment_bytes, fragment_len,
                  start_offset, output ready);
endinterface

interface nts_out_if
  import nts_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [NGRAM_W-1:0]  found_ngram;
  logic [OFF_W-1:0]    next_offset;

  modport source (output valid, status, found_ngram, next_offset, input ready);
  modport sink   (input valid, status, found_ngram, next_offset, output ready);
endinterface

// ===== rtl/nts_store.sv =====
// N-gram store: single-port-write, single-port-read synchronous RAM.
// Read data is registered. Depends on nts_pkg.
module nts_store
  import nts_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] waddr,
  input  logic [NGRAM_W-1:0]               wdata,
  input  logic                             re,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] raddr,
  output logic [NGRAM_W-1:0]               rdata
);

  logic [NGRAM_W-1:0] mem [TABLE_ENTRIES];
  logic [NGRAM_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/nts_match.sv =====
// Per-entry fragment matcher: checks every byte position of one n-gram at once
// and reports the first one at or after the start offset. Depends on nts_pkg.
module nts_match
  import nts_pkg::*;
#(
  parameter int NGRAM_BYTES = NGRAM_BYTES_DEF,
  parameter int OFS_W       = OFF_W
) (
  input  logic [NGRAM_W-1:0] word,
  input  logic [FRAG_W-1:0]  frag,
  input  logic [FLEN_W-1:0]  flen,
  input  logic [OFS_W-1:0]   base,   // byte offset of this entry
  input  logic [OFS_W-1:0]   start,
  output match_res_t         res
);

  logic [7:0]             eb [NGRAM_BYTES+2];
  logic [7:0]             fb [3];
  logic [NGRAM_BYTES-1:0] ok;
  logic [OFS_W-1:0]       gap;

  // positions below 'gap' lie before the start offset
  assign gap = (start > base) ? (start - base) : '0;

  always_comb begin
    // bytes past the stored word (and past the entry) read as zero
    for (int j = 0; j < NGRAM_BYTES + 2; j++) begin
      eb[j] = 8'(word >> (8 * j));
    end
    for (int i = 0; i < 3; i++) begin
      fb[i] = frag[8*i +: 8];
    end
    for (int k = 0; k < NGRAM_BYTES; k++) begin
      ok[k] = (OFS_W'(k) >= gap)
           && ((k + int'(flen)) <= NGRAM_BYTES)
           && ((flen < 2'd1) || (eb[k]   == fb[0]))
           && ((flen < 2'd2) || (eb[k+1] == fb[1]))
           && ((flen < 2'd3) || (eb[k+2] == fb[2]));
    end
  end

  always_comb begin
    res = '0;
    for (int k = NGRAM_BYTES - 1; k >= 0; k--) begin
      if (ok[k]) begin
        res.hit = 1'b1;
        res.pos = POS_W'(k);
      end
    end
  end

endmodule

// ===== rtl/ngram_table_fragment_search.sv =====
// Top level of the n-gram table fragment search block.
// Depends on nts_pkg, nts_if, nts_store and nts_match.
//
// Usage
//   in_ch  : one item per handshake. opcode LOAD appends entry_bytes to the
//            table (dropped with status FULL once TABLE_ENTRIES are held);
//            opcode SEARCH looks for fragment_bytes/fragment_len at or after
//            start_offset, only matches lying inside a single n-gram count.
//   out_ch : exactly one result item per input item, in order.
// Timing
//   A load, or a search whose start is at/after the table end, is written to
//   the output register at the accepting edge; the result is offered in the next cycle.
//   Other searches scan the RAM from entry 0, one entry per cycle through the
//   single read port; a hit or the table end puts the result in the result
//   register, from which ST_RESP loads the output register once it is free.
//   Only one item is worked on at a time; in_ch.ready is high in idle while
//   the output register is empty or being emptied, so a new item may be
//   taken while a result is still waiting.
// Reset
//   rst_n (synchronous, active low) empties the table; RAM contents are not
//   cleared, entries above the count are never read. No clearing pass.
// Back-pressure
//   A stalled out_ch holds the result register; the block then waits and
//   takes no further item.
module ngram_table_fragment_search
  import nts_pkg::*;
#(
  parameter int NGRAM_BYTES   = NGRAM_BYTES_DEF,
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input logic      clk,
  input logic      rst_n,
  nts_in_if.sink   in_ch,
  nts_out_if.source out_ch
);

  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int SIZE_W = $clog2(TABLE_ENTRIES * NGRAM_BYTES + 1);
  // internal offsets wide enough for both the table size and the port offset
  localparam int OFS_W  = (SIZE_W > OFF_W) ? SIZE_W : OFF_W;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [OFS_W-1:0]   size_r, size_nxt;      // table size in bytes
  logic [CNT_W-1:0]   rd_idx_r, rd_idx_nxt;  // next entry to read
  logic [OFS_W-1:0]   ibase_r, ibase_nxt;    // byte offset of rd_idx_r
  logic               dv_r, dv_nxt;          // read data valid this cycle
  logic [OFS_W-1:0]   dbase_r, dbase_nxt;    // byte offset of read data

  logic [FRAG_W-1:0]  frag_r, frag_nxt;
  logic [FLEN_W-1:0]  flen_r, flen_nxt;
  logic [OFS_W-1:0]   start_r, start_nxt;

  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [NGRAM_W-1:0]  res_ngram_r, res_ngram_nxt;
  logic [OFS_W-1:0]    res_next_r, res_next_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [NGRAM_W-1:0]  out_ngram_r, out_ngram_nxt;
  logic [OFS_W-1:0]    out_next_r, out_next_nxt;

  logic               in_fire, out_free, full, is_search, past_end;
  logic               issue, hit_now, miss_now;
  logic [OFS_W-1:0]   start_ext;
  logic               st_we;
  logic [NGRAM_W-1:0] rdata;
  match_res_t         mres;

  // ---------------------------------------------------------------- storage
  nts_store #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata (in_ch.entry_bytes),
    .re    (issue),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (rdata)
  );

  // matcher looks at the entry whose data has just come out of the RAM
  nts_match #(
    .NGRAM_BYTES (NGRAM_BYTES),
    .OFS_W       (OFS_W)
  ) u_match (
    .word  (rdata),
    .frag  (frag_r),
    .flen  (flen_r),
    .base  (dbase_r),
    .start (start_r),
    .res   (mres)
  );

  // ---------------------------------------------------------------- handshake
  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign start_ext = OFS_W'(in_ch.start_offset);
  assign full      = (count_r == CNT_W'(TABLE_ENTRIES));
  assign is_search = (in_ch.opcode == OP_SEARCH);
  assign past_end  = (start_ext >= size_r);
  assign st_we     = in_fire && !is_search && !full;

  // scan: one read issued per cycle until the table end or a hit
  assign hit_now  = (state_r == ST_SCAN) && dv_r && mres.hit;
  assign miss_now = (state_r == ST_SCAN) && dv_r && !mres.hit && (rd_idx_r == count_r);
  assign issue    = (state_r == ST_SCAN) && (rd_idx_r < count_r) && !hit_now;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && is_search && !past_end) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit_now || miss_now) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_comb begin
    count_nxt      = count_r;
    size_nxt       = size_r;
    rd_idx_nxt     = rd_idx_r;
    ibase_nxt      = ibase_r;
    dv_nxt         = issue;
    dbase_nxt      = dbase_r;
    frag_nxt       = frag_r;
    flen_nxt       = flen_r;
    start_nxt      = start_r;
    res_status_nxt = res_status_r;
    res_ngram_nxt  = res_ngram_r;
    res_next_nxt   = res_next_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_ngram_nxt  = out_ngram_r;
    out_next_nxt   = out_next_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          frag_nxt   = in_ch.fragment_bytes;
          flen_nxt   = in_ch.fragment_len;
          start_nxt  = start_ext;
          rd_idx_nxt = '0;
          ibase_nxt  = '0;
          if (!is_search) begin
            out_valid_nxt = 1'b1;
            out_ngram_nxt = '0;
            if (full) begin
              out_status_nxt = STATUS_FULL;
              out_next_nxt   = size_r;
            end else begin
              count_nxt      = count_r + CNT_W'(1);
              size_nxt       = size_r + OFS_W'(NGRAM_BYTES);
              out_status_nxt = STATUS_OK;
              out_next_nxt   = size_r + OFS_W'(NGRAM_BYTES);
            end
          end else if (past_end) begin
            // start already at or past the end: offset comes back as given
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_MISS;
            out_ngram_nxt  = '0;
            out_next_nxt   = start_ext;
          end
        end
      end
      ST_SCAN: begin
        if (issue) begin
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
          ibase_nxt  = ibase_r + OFS_W'(NGRAM_BYTES);
          dbase_nxt  = ibase_r;
        end
        if (hit_now) begin
          res_status_nxt = STATUS_OK;
          res_ngram_nxt  = rdata;
          res_next_nxt   = dbase_r + OFS_W'(mres.pos) + OFS_W'(1);
        end else if (miss_now) begin
          res_status_nxt = STATUS_MISS;
          res_ngram_nxt  = '0;
          res_next_nxt   = size_r;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_ngram_nxt  = res_ngram_r;
          out_next_nxt   = res_next_r;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      size_r      <= '0;
      rd_idx_r    <= '0;
      ibase_r     <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      size_r      <= size_nxt;
      rd_idx_r    <= rd_idx_nxt;
      ibase_r     <= ibase_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dbase_r      <= dbase_nxt;
    frag_r       <= frag_nxt;
    flen_r       <= flen_nxt;
    start_r      <= start_nxt;
    res_status_r <= res_status_nxt;
    res_ngram_r  <= res_ngram_nxt;
    res_next_r   <= res_next_nxt;
    out_status_r <= out_status_nxt;
    out_ngram_r  <= out_ngram_nxt;
    out_next_r   <= out_next_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.found_ngram = out_ngram_r;
  assign out_ch.next_offset = out_next_r[OFF_W-1:0];

  // ---------------------------------------------------------------- checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_ENTRIES))
    else $error("entry count beyond table depth");

  a_size_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
    32'(size_r) == 32'(count_r) * NGRAM_BYTES)
    else $error("table size out of step with entry count");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_idx_r <= count_r)
    else $error("scan read beyond stored entries");

  a_data_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r |-> (state_r == ST_SCAN))
    else $error("read data arriving outside a scan");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_we |-> (state_r == ST_IDLE) && !full)
    else $error("store write outside idle or into a full table");

endmodule

// ===== bench/ngram_table_fragment_search_tb.sv =====
// Self-checking bench for ngram_table_fragment_search: directed rows, then random items.
// Depends on nts_pkg and the nts_in_if / nts_out_if interfaces; drives the block through them.
module ngram_table_fragment_search_tb;
  import nts_pkg::*;

  localparam int RANDOM_ITEMS = 122;
  localparam int HOLD_AT      = 40;     // receiver starts its one long hold-off at this random item
  localparam int DRAIN_AT     = 90;     // sender pauses until the table has answered everything
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 8 * (TABLE_ENTRIES_DEF + HOLD_CYCLES);
  localparam int SETTLE       = TABLE_ENTRIES_DEF + 16;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [NGRAM_W-1:0]  entry;
    logic [FRAG_W-1:0]   frag;
    logic [FLEN_W-1:0]   flen;
    logic [OFF_W-1:0]    start;
  } search_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [NGRAM_W-1:0]  ngram;
    logic [OFF_W-1:0]    next_off;
  } search_result_t;

  // One directed row; typed = 1 means the expected result is given in the row
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [NGRAM_W-1:0]  entry;
    logic [FRAG_W-1:0]   frag;
    logic [FLEN_W-1:0]   flen;
    logic [OFF_W-1:0]    start;
    logic                typed;
    logic [STATUS_W-1:0] status;
    logic [NGRAM_W-1:0]  ngram;
    logic [OFF_W-1:0]    next_off;
  } directed_row_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_EVERY_THIRD
  } rx_mode_t;

  localparam int DIRECTED_COUNT = 18;

  // Table after the four loads below: 00 00 00 | FF FF FF | 61 62 63 | 63 61 62
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // empty table: any start is at or past the end
    '{OP_SEARCH, 24'h000000, 24'h000000, 2'd1, 14'd0,     1'b1, STATUS_MISS, 24'h0, 14'd0},
    '{OP_SEARCH, 24'h000000, 24'hFFFFFF, 2'd3, 14'h3FFF,  1'b1, STATUS_MISS, 24'h0, 14'h3FFF},
    '{OP_LOAD,   24'h000000, 24'hFFFFFF, 2'd3, 14'h3FFF,  1'b1, STATUS_OK,   24'h0, 14'd3},
    '{OP_LOAD,   24'hFFFFFF, 24'h000000, 2'd0, 14'd0,     1'b1, STATUS_OK,   24'h0, 14'd6},
    '{OP_LOAD,   24'h636261, 24'h000000, 2'd0, 14'd0,     1'b1, STATUS_OK,   24'h0, 14'd9},
    '{OP_LOAD,   24'h626163, 24'h000000, 2'd0, 14'd0,     1'b1, STATUS_OK,   24'h0, 14'd12},
    '{OP_SEARCH, 24'h000000, 24'h006261, 2'd2, 14'd0,     1'b0, STATUS_OK,   24'h0, 14'd0},
    // "cc" only appears across the record boundary
    '{OP_SEARCH, 24'h000000, 24'h006363, 2'd2, 14'd0,     1'b0, STATUS_OK,   24'h0, 14'd0},
    // empty fragment hits at the start itself
    '{OP_SEARCH, 24'h000000, 24'hA5A5A5, 2'd0, 14'd4,     1'b0, STATUS_OK,   24'h0, 14'd0},
    // bytes past the length are junk and must be ignored
    '{OP_SEARCH, 24'h000000, 24'hFFFF61, 2'd1, 14'd0,     1'b0, STATUS_OK,   24'h0, 14'd0},
    '{OP_SEARCH, 24'h000000, 24'h000061, 2'd1, 14'd12,    1'b1, STATUS_MISS, 24'h0, 14'd12},
    '{OP_SEARCH, 24'h000000, 24'hFFFFFF, 2'd3, 14'd0,     1'b0, STATUS_OK,   24'h0, 14'd0},
    '{OP_SEARCH, 24'h000000, 24'hFFFFFF, 2'd3, 14'd4,     1'b0, STATUS_OK,   24'h0, 14'd0},
    '{OP_SEARCH, 24'h000000, 24'h000000, 2'd3, 14'd0,     1'b0, STATUS_OK,   24'h0, 14'd0},
    '{OP_SEARCH, 24'h000000, 24'h000062, 2'd1, 14'd11,    1'b0, STATUS_OK,   24'h0, 14'd0},
    '{OP_SEARCH, 24'h000000, 24'h000063, 2'd1, 14'd7,     1'b0, STATUS_OK,   24'h0, 14'd0},
    '{OP_SEARCH, 24'h000000, 24'h000000, 2'd0, 14'd11,    1'b0, STATUS_OK,   24'h0, 14'd0},
    '{OP_SEARCH, 24'h000000, 24'h000000, 2'd0, 14'd12,    1'b1, STATUS_MISS, 24'h0, 14'd12}
  };

  // Small alphabet so random loads repeat bytes and fragments hit often
  localparam logic [7:0] ALPHABET [4] = '{8'h61, 8'h62, 8'h00, 8'hFF};

  logic clk;
  logic rst_n;

  nts_in_if  in_ch ();
  nts_out_if out_ch ();

  ngram_table_fragment_search dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Mirror of the block's table
  logic [NGRAM_W-1:0] ngram_mirror [TABLE_ENTRIES_DEF];
  int unsigned        stored_count;

  search_result_t pending_results [$];
  search_result_t oldest;
  int             fail_count;
  int             quiet_cycles;

  int       burst_left;
  int       gap_len;
  bit       hold_req;
  int       hold_left;
  int       rx_cycle;
  rx_mode_t rx_mode;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Applies one item to the mirror and returns what the block must answer.
  function automatic search_result_t table_outcome(input search_item_t it);
    search_result_t r;
    int unsigned    size;
    int unsigned    p;
    int unsigned    pos;
    bit             hit;
    r = '0;
    size = stored_count * NGRAM_BYTES_DEF;
    if (it.opcode == OP_LOAD) begin
      if (stored_count >= TABLE_ENTRIES_DEF) begin
        r.status = STATUS_FULL;
      end else begin
        ngram_mirror[stored_count] = it.entry;
        stored_count++;
        size += NGRAM_BYTES_DEF;
        r.status = STATUS_OK;
      end
      r.next_off = OFF_W'(size);
      return r;
    end
    // start at or beyond the end: offset comes back untouched
    if (it.start >= size) begin
      r.status   = STATUS_MISS;
      r.next_off = it.start;
      return r;
    end
    for (p = it.start; p < size; p++) begin
      // skip positions whose match would run into the next record
      if ((p % NGRAM_BYTES_DEF) + it.flen > NGRAM_BYTES_DEF) continue;
      hit = 1'b1;
      for (int i = 0; i < it.flen; i++) begin
        pos = p + i;
        if (ngram_mirror[pos / NGRAM_BYTES_DEF][8 * (pos % NGRAM_BYTES_DEF) +: 8] !=
            it.frag[8 * i +: 8])
          hit = 1'b0;
      end
      if (hit) begin
        r.status   = STATUS_OK;
        r.ngram    = ngram_mirror[p / NGRAM_BYTES_DEF];
        r.next_off = OFF_W'(p + 1);
        return r;
      end
    end
    r.status   = STATUS_MISS;
    r.next_off = OFF_W'(size);
    return r;
  endfunction

  // Offers one item in the current burst; files the expectation once taken.
  task automatic offer_item(input search_item_t it, input bit typed, input search_result_t want);
    search_result_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap_len > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap_len) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid          <= 1'b1;
    in_ch.opcode         <= it.opcode;
    in_ch.entry_bytes    <= it.entry;
    in_ch.fragment_bytes <= it.frag;
    in_ch.fragment_len   <= it.flen;
    in_ch.start_offset   <= it.start;
    do @(posedge clk); while (!in_ch.ready);
    predicted = table_outcome(it);
    pending_results = {pending_results, (typed ? want : predicted)};
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Main stimulus
  initial begin
    search_item_t   it;
    search_result_t want;
    search_result_t none;
    int unsigned    pick;
    int unsigned    r;
    int unsigned    w;
    int unsigned    l;
    none                 = '0;
    stored_count         = 0;
    fail_count           = 0;
    burst_left           = 0;
    hold_req             = 1'b0;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.opcode         <= OP_LOAD;
    in_ch.entry_bytes    <= '0;
    in_ch.fragment_bytes <= '0;
    in_ch.fragment_len   <= '0;
    in_ch.start_offset   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (int n = 0; n < DIRECTED_COUNT; n++) begin
      it   = '{DIRECTED_ROWS[n].opcode, DIRECTED_ROWS[n].entry, DIRECTED_ROWS[n].frag,
               DIRECTED_ROWS[n].flen, DIRECTED_ROWS[n].start};
      want = '{DIRECTED_ROWS[n].status, DIRECTED_ROWS[n].ngram, DIRECTED_ROWS[n].next_off};
      offer_item(it, DIRECTED_ROWS[n].typed, want);
    end
    wait_all_results();

    // Random part: mostly searches for fragments cut out of stored n-grams
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == HOLD_AT) hold_req = 1'b1;
      if (n == DRAIN_AT) wait_all_results();
      pick     = $urandom_range(0, 19);
      it.entry = NGRAM_W'($urandom);
      it.frag  = FRAG_W'($urandom);
      it.flen  = FLEN_W'($urandom_range(0, 3));
      it.start = OFF_W'($urandom_range(0, 16383));
      if (pick < 6) begin
        it.opcode = OP_LOAD;
        if ($urandom_range(0, 3) != 0)
          for (int b = 0; b < STORED_BYTES; b++)
            it.entry[8 * b +: 8] = ALPHABET[$urandom_range(0, 3)];
      end else if (pick < 17) begin
        it.opcode = OP_SEARCH;
        r = $urandom_range(0, stored_count - 1);
        w = $urandom_range(0, NGRAM_BYTES_DEF - 1);
        // now and then let the length run past the record or drop to zero
        l = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3)
                                        : $urandom_range(1, NGRAM_BYTES_DEF - w);
        for (int i = 0; i < l; i++)
          it.frag[8 * i +: 8] = (w + i < STORED_BYTES) ? ngram_mirror[r][8 * (w + i) +: 8]
                                                        : 8'h00;
        it.flen = FLEN_W'(l);
        if ($urandom_range(0, 7) != 0)
          it.start = OFF_W'($urandom_range(0, r * NGRAM_BYTES_DEF + w));
      end else begin
        // junk fragment; start inside the table half the time
        it.opcode = OP_SEARCH;
        if ($urandom_range(0, 1) == 0)
          it.start = OFF_W'($urandom_range(0, stored_count * NGRAM_BYTES_DEF));
      end
      offer_item(it, 1'b0, none);
    end
    wait_all_results();

    // catch any stray result item
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("ngram_table_fragment_search_tb: clean");
    end else begin
      $display("ngram_table_fragment_search_tb: errors");
    end
    $finish;
  end

  // Receiver: its own stall pattern, re-picked at random as rx_cycle advances, plus one long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    rx_cycle     = 0;
    hold_left    = 0;
    rx_mode      = RX_OPEN;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle % 50 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:        out_ch.ready <= 1'b1;
          RX_COIN:        out_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE:      out_ch.ready <= ($urandom_range(0, 4) == 0);
          RX_EVERY_THIRD: out_ch.ready <= (rx_cycle % 3 == 0);
          default:        out_ch.ready <= 1'b1;
        endcase
      end
    end
  end

  // Result checker: every result item against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result item with nothing expected: status %0d ngram %h offset %0d",
                 $time, out_ch.status, out_ch.found_ngram, out_ch.next_offset);
        fail_count++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_ch.status !== oldest.status) begin
          $display("%0t: status expected %0d actual %0d", $time, oldest.status, out_ch.status);
          fail_count++;
        end
        if (out_ch.found_ngram !== oldest.ngram) begin
          $display("%0t: found_ngram expected %h actual %h",
                   $time, oldest.ngram, out_ch.found_ngram);
          fail_count++;
        end
        if (out_ch.next_offset !== oldest.next_off) begin
          $display("%0t: next_offset expected %0d actual %0d",
                   $time, oldest.next_off, out_ch.next_offset);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long with no item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("ngram_table_fragment_search_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
